>>> sv/iqfr_pkg.sv
// iqfr_pkg: shared constants, codes and controller/datapath link types
// for the IQ fragment reassembler. No dependencies.
`default_nettype none
package iqfr_pkg;

  localparam int DEF_MAX_SLOTS        = 4;
  localparam int DEF_FRAGS_PER_SET    = 4;
  localparam int DEF_SAMPLES_PER_FRAG = 8;

  localparam logic [15:0] MARKER_RESET = 16'hFFFF;
  localparam logic [9:0]  TOTAL_MAX    = 10'd1023;

  localparam logic [1:0] CMD_HDR = 2'd0;
  localparam logic [1:0] CMD_SMP = 2'd1;
  localparam logic [1:0] CMD_CLR = 2'd2;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_HDR    = 2'd1;
  localparam logic [1:0] KIND_SMP    = 2'd2;

  localparam logic [2:0] STS_OK         = 3'd0;
  localparam logic [2:0] STS_NO_SLOT    = 3'd1;
  localparam logic [2:0] STS_BAD_FRAG   = 3'd2;
  localparam logic [2:0] STS_NO_PENDING = 3'd3;
  localparam logic [2:0] STS_DROPPED    = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic emit_hdr;
    logic emit_smp;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic emit_start;
    logic pos_last;
  } dp_sts_t;

endpackage
`default_nettype wire

>>> sv/iqfr_ctrl.sv
// iqfr_ctrl: handshake and record emission state machine.
// Depends on iqfr_pkg.
`default_nettype none
module iqfr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  output iqfr_pkg::ctl_cmd_t     cmd,
  input  iqfr_pkg::dp_sts_t      sts
);
  import iqfr_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HDR  = 2'd1;
  localparam logic [1:0] ST_SMP  = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign busy         = (state_r != ST_IDLE);
  assign cmd.accept   = start && !busy;
  assign cmd.emit_hdr = (state_r == ST_HDR);
  assign cmd.emit_smp = (state_r == ST_SMP);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (cmd.accept && sts.emit_start) state_nxt = ST_HDR;
      ST_HDR:  state_nxt = ST_SMP;
      ST_SMP:  if (sts.pos_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  a_hdr_then_smp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_HDR |=> state_r == ST_SMP) else $error("header not followed by samples");
  a_smp_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SMP && sts.pos_last) |=> state_r == ST_IDLE)
    else $error("emission did not end");
  a_start_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && sts.emit_start) |=> state_r == ST_HDR) else $error("emission not started");

endmodule
`default_nettype wire

>>> sv/iqfr_dp.sv
// iqfr_dp: slot table, pending fragment state, sample memory and result registers.
// Depends on iqfr_pkg.
`default_nettype none
module iqfr_dp #(
  parameter int MAX_SLOTS        = iqfr_pkg::DEF_MAX_SLOTS,
  parameter int FRAGS_PER_SET    = iqfr_pkg::DEF_FRAGS_PER_SET,
  parameter int SAMPLES_PER_FRAG = iqfr_pkg::DEF_SAMPLES_PER_FRAG
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  iqfr_pkg::ctl_cmd_t      cmd,
  output iqfr_pkg::dp_sts_t       sts,
  input  wire logic               cfg_valid,
  input  wire logic [15:0]        cfg_data,
  input  wire logic [1:0]         in_command,
  input  wire logic [15:0]        in_conn_id,
  input  wire logic [7:0]         in_report_idx,
  input  wire logic [15:0]        in_timestamp_sn,
  input  wire logic [15:0]        in_es_sn,
  input  wire logic signed [7:0]  in_rssi,
  input  wire logic [7:0]         in_sample_count,
  input  wire logic               in_link_ready,
  input  wire logic signed [15:0] in_i_data,
  input  wire logic signed [15:0] in_q_data,
  output logic                    out_valid,
  output logic [1:0]              out_kind,
  output logic [2:0]              out_status,
  output logic [15:0]             out_conn_id,
  output logic [9:0]              out_total_samples,
  output logic signed [7:0]       out_rssi,
  output logic [15:0]             out_es_sn,
  output logic [15:0]             out_timestamp_sn,
  output logic signed [15:0]      out_i,
  output logic signed [15:0]      out_q,
  output logic [31:0]             out_drop_count,
  output logic                    out_last
);
  import iqfr_pkg::*;

  localparam int SET    = FRAGS_PER_SET * SAMPLES_PER_FRAG;
  localparam int DEPTH  = MAX_SLOTS * SET;
  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int POS_W  = (SET > 1) ? $clog2(SET) : 1;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NF_W   = $clog2(FRAGS_PER_SET + 1);
  localparam int OFF_W  = $clog2(SAMPLES_PER_FRAG + 1);

  logic [15:0]      marker_r;
  logic [15:0]      owner_r [MAX_SLOTS];
  logic [15:0]      owner_nxt [MAX_SLOTS];
  logic [NF_W-1:0]  nf_r [MAX_SLOTS];
  logic [NF_W-1:0]  nf_nxt [MAX_SLOTS];
  logic [9:0]       tot_r [MAX_SLOTS];
  logic [9:0]       tot_nxt [MAX_SLOTS];
  logic [7:0]       rssi_r [MAX_SLOTS];
  logic [7:0]       rssi_nxt [MAX_SLOTS];
  logic [15:0]      es_r [MAX_SLOTS];
  logic [15:0]      es_nxt [MAX_SLOTS];
  logic [15:0]      ts_r [MAX_SLOTS];
  logic [15:0]      ts_nxt [MAX_SLOTS];
  logic [SET-1:0]   mask_r [MAX_SLOTS];
  logic [SET-1:0]   mask_nxt [MAX_SLOTS];

  logic [SLOT_W-1:0] pslot_r, pslot_nxt;
  logic [OFF_W-1:0]  poff_r, poff_nxt;
  logic [7:0]        prem_r, prem_nxt;
  logic              pfin_r, pfin_nxt;
  logic [31:0]       drop_r, drop_nxt;
  logic [SLOT_W-1:0] eslot_r, eslot_nxt;
  logic [POS_W-1:0]  rd_pos_r;

  logic [31:0]       mem [DEPTH];
  logic [31:0]       rdata_r;
  logic              bit_r;

  logic [1:0]  kind_r;
  logic [2:0]  status_r;
  logic [15:0] conn_r;
  logic [9:0]  total_r;
  logic [7:0]  orssi_r;
  logic [15:0] oes_r;
  logic [15:0] ots_r;
  logic        last_r;
  logic        valid_r;

  logic              match_hit, free_hit;
  logic [SLOT_W-1:0] match_idx, free_idx;

  // first owner match wins over any free slot; lowest index first
  always_comb begin
    match_hit = 1'b0;
    match_idx = '0;
    free_hit  = 1'b0;
    free_idx  = '0;
    for (int s = MAX_SLOTS - 1; s >= 0; s--) begin
      if (owner_r[s] == in_conn_id) begin
        match_hit = 1'b1;
        match_idx = SLOT_W'(s);
      end
      if (owner_r[s] == marker_r) begin
        free_hit = 1'b1;
        free_idx = SLOT_W'(s);
      end
    end
  end

  logic [2:0]        res_status;
  logic              complete;
  logic [SLOT_W-1:0] cslot;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [POS_W-1:0]  wpos;
  logic [SLOT_W-1:0] hs;
  logic [NF_W-1:0]   nf_e;
  logic [9:0]        tot_e;
  logic [15:0]       ts_e;
  logic [10:0]       sum;

  always_comb begin
    for (int s = 0; s < MAX_SLOTS; s++) begin
      owner_nxt[s] = owner_r[s];
      nf_nxt[s]    = nf_r[s];
      tot_nxt[s]   = tot_r[s];
      rssi_nxt[s]  = rssi_r[s];
      es_nxt[s]    = es_r[s];
      ts_nxt[s]    = ts_r[s];
      mask_nxt[s]  = mask_r[s];
    end
    pslot_nxt  = pslot_r;
    poff_nxt   = poff_r;
    prem_nxt   = prem_r;
    pfin_nxt   = pfin_r;
    drop_nxt   = drop_r;
    eslot_nxt  = eslot_r;
    res_status = STS_OK;
    complete   = 1'b0;
    cslot      = pslot_r;
    wr_en      = 1'b0;
    wpos       = POS_W'((32'(nf_r[pslot_r]) - 32'd1) * 32'(SAMPLES_PER_FRAG) + 32'(poff_r));
    wr_addr    = ADDR_W'(32'(pslot_r) * 32'(SET) + 32'(wpos));
    hs         = match_hit ? match_idx : free_idx;
    nf_e       = match_hit ? nf_r[hs] : '0;
    tot_e      = match_hit ? tot_r[hs] : '0;
    ts_e       = match_hit ? ts_r[hs] : '0;
    sum        = '0;
    sts.emit_start = 1'b0;
    sts.pos_last   = (32'(rd_pos_r) == SET - 1);

    if (cmd.accept) begin
      unique case (in_command)
        CMD_HDR: begin
          prem_nxt = '0;
          pfin_nxt = 1'b0;
          if (!(match_hit || free_hit)) begin
            res_status = STS_NO_SLOT;
          end else begin
            if (!match_hit) begin
              owner_nxt[hs] = in_conn_id;
              mask_nxt[hs]  = '0;
              rssi_nxt[hs]  = '0;
              es_nxt[hs]    = '0;
            end
            if (in_report_idx == 8'd0) begin
              tot_e        = '0;
              ts_e         = in_timestamp_sn;
              nf_e         = '0;
              rssi_nxt[hs] = in_rssi;
              es_nxt[hs]   = in_es_sn;
            end
            nf_nxt[hs]  = nf_e;
            tot_nxt[hs] = tot_e;
            ts_nxt[hs]  = ts_e;
            if (32'(in_report_idx) >= 32'(FRAGS_PER_SET) || in_timestamp_sn != ts_e ||
                8'(nf_e) != in_report_idx) begin
              res_status = STS_BAD_FRAG;
            end else begin
              sum         = {1'b0, tot_e} + 11'(in_sample_count);
              tot_nxt[hs] = (sum > 11'(TOTAL_MAX)) ? TOTAL_MAX : sum[9:0];
              nf_nxt[hs]  = NF_W'(32'(in_report_idx) + 32'd1);
              pslot_nxt   = hs;
              poff_nxt    = '0;
              prem_nxt    = in_sample_count;
              pfin_nxt    = (32'(in_report_idx) == FRAGS_PER_SET - 1);
              if (in_sample_count == 8'd0 && pfin_nxt) begin
                pfin_nxt = 1'b0;
                complete = 1'b1;
                cslot    = hs;
              end
            end
          end
        end
        CMD_SMP: begin
          if (prem_r == 8'd0) begin
            res_status = STS_NO_PENDING;
          end else begin
            if (32'(poff_r) < SAMPLES_PER_FRAG && nf_r[pslot_r] != '0) begin
              wr_en = 1'b1;
              mask_nxt[pslot_r][wpos] = 1'b1;
            end
            if (32'(poff_r) < SAMPLES_PER_FRAG) poff_nxt = poff_r + 1'b1;
            prem_nxt = prem_r - 8'd1;
            if (prem_r == 8'd1 && pfin_r) begin
              pfin_nxt = 1'b0;
              complete = 1'b1;
            end
          end
        end
        CMD_CLR: begin
          if (match_hit) begin
            owner_nxt[match_idx] = marker_r;
            nf_nxt[match_idx]    = '0;
            tot_nxt[match_idx]   = '0;
            rssi_nxt[match_idx]  = '0;
            es_nxt[match_idx]    = '0;
            ts_nxt[match_idx]    = '0;
            mask_nxt[match_idx]  = '0;
            if (pslot_r == match_idx) begin
              prem_nxt = '0;
              pfin_nxt = 1'b0;
            end
          end
        end
        default: res_status = STS_BAD_FRAG;
      endcase
      if (complete) begin
        if (!in_link_ready) begin
          drop_nxt   = drop_r + 32'd1;
          res_status = STS_DROPPED;
        end else begin
          sts.emit_start = 1'b1;
          eslot_nxt      = cslot;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= MARKER_RESET;
      for (int s = 0; s < MAX_SLOTS; s++) begin
        owner_r[s] <= MARKER_RESET;
        nf_r[s]    <= '0;
        tot_r[s]   <= '0;
        rssi_r[s]  <= '0;
        es_r[s]    <= '0;
        ts_r[s]    <= '0;
        mask_r[s]  <= '0;
      end
      pslot_r <= '0;
      poff_r  <= '0;
      prem_r  <= '0;
      pfin_r  <= 1'b0;
      drop_r  <= '0;
      eslot_r <= '0;
      valid_r <= 1'b0;
    end else begin
      if (cfg_valid) marker_r <= cfg_data;
      for (int s = 0; s < MAX_SLOTS; s++) begin
        owner_r[s] <= owner_nxt[s];
        nf_r[s]    <= nf_nxt[s];
        tot_r[s]   <= tot_nxt[s];
        rssi_r[s]  <= rssi_nxt[s];
        es_r[s]    <= es_nxt[s];
        ts_r[s]    <= ts_nxt[s];
        mask_r[s]  <= mask_nxt[s];
      end
      pslot_r <= pslot_nxt;
      poff_r  <= poff_nxt;
      prem_r  <= prem_nxt;
      pfin_r  <= pfin_nxt;
      drop_r  <= drop_nxt;
      eslot_r <= eslot_nxt;
      valid_r <= cmd.accept || cmd.emit_hdr || cmd.emit_smp;
    end
  end

  // sample memory, read only during record emission
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {in_i_data, in_q_data};
    if (cmd.emit_smp) begin
      rdata_r <= mem[ADDR_W'(32'(eslot_r) * 32'(SET) + 32'(rd_pos_r))];
      bit_r   <= mask_r[eslot_r][rd_pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_hdr)      rd_pos_r <= '0;
    else if (cmd.emit_smp) rd_pos_r <= rd_pos_r + 1'b1;
    if (cmd.accept) begin
      kind_r   <= KIND_STATUS;
      status_r <= res_status;
      conn_r   <= in_conn_id;
      total_r  <= '0;
      orssi_r  <= '0;
      oes_r    <= '0;
      ots_r    <= '0;
      last_r   <= !sts.emit_start;
    end else if (cmd.emit_hdr || cmd.emit_smp) begin
      kind_r   <= cmd.emit_hdr ? KIND_HDR : KIND_SMP;
      status_r <= STS_OK;
      conn_r   <= owner_r[eslot_r];
      total_r  <= tot_r[eslot_r];
      orssi_r  <= rssi_r[eslot_r];
      oes_r    <= es_r[eslot_r];
      ots_r    <= ts_r[eslot_r];
      last_r   <= cmd.emit_smp && sts.pos_last;
    end
  end

  assign out_valid         = valid_r;
  assign out_kind          = kind_r;
  assign out_status        = status_r;
  assign out_conn_id       = conn_r;
  assign out_total_samples = total_r;
  assign out_rssi          = orssi_r;
  assign out_es_sn         = oes_r;
  assign out_timestamp_sn  = ots_r;
  assign out_i             = (kind_r == KIND_SMP && bit_r) ? rdata_r[31:16] : '0;
  assign out_q             = (kind_r == KIND_SMP && bit_r) ? rdata_r[15:0] : '0;
  assign out_drop_count    = drop_r;
  assign out_last          = last_r;

endmodule
`default_nettype wire

>>> sv/iq_fragment_reassembler_unit.sv
// iq_fragment_reassembler_unit: top level, controller plus datapath.
// Depends on iqfr_pkg, iqfr_ctrl, iqfr_dp.
//
// Usage:
//   Input: an item is taken on a rising edge with start high and busy low.
//   The block takes one header, sample or clear item per cycle while busy
//   stays low.
//   Results: out_valid marks each result for exactly one cycle; the receiver
//   cannot stall, so every strobed result is a completed transfer.
//   Every item gives one status result in the cycle after it is taken.
//   An item completing a set with in_link_ready high is followed, after its
//   status result, by a record header, then FRAGS_PER_SET*SAMPLES_PER_FRAG
//   samples on consecutive cycles; busy stays high while the header and all
//   samples are emitted.
//   out_last flags the final result of each item.
//   Config: cfg_ready is always high; write the connection marker only while
//   idle.
//   Reset (rst_n low, synchronous): all slots free, no pending fragment,
//   drop count zero, marker back to 0xFFFF. Sample memory is not cleared;
//   positions never written since the slot was last taken or cleared read as zero.
`default_nettype none
module iq_fragment_reassembler_unit #(
  parameter int MAX_SLOTS        = iqfr_pkg::DEF_MAX_SLOTS,
  parameter int FRAGS_PER_SET    = iqfr_pkg::DEF_FRAGS_PER_SET,
  parameter int SAMPLES_PER_FRAG = iqfr_pkg::DEF_SAMPLES_PER_FRAG
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [15:0]        cfg_data,
  input  wire logic [1:0]         in_command,
  input  wire logic [15:0]        in_conn_id,
  input  wire logic [7:0]         in_report_idx,
  input  wire logic [15:0]        in_timestamp_sn,
  input  wire logic [15:0]        in_es_sn,
  input  wire logic signed [7:0]  in_rssi,
  input  wire logic [7:0]         in_sample_count,
  input  wire logic               in_link_ready,
  input  wire logic signed [15:0] in_i_data,
  input  wire logic signed [15:0] in_q_data,
  output logic                    out_valid,
  output logic [1:0]              out_kind,
  output logic [2:0]              out_status,
  output logic [15:0]             out_conn_id,
  output logic [9:0]              out_total_samples,
  output logic signed [7:0]       out_rssi,
  output logic [15:0]             out_es_sn,
  output logic [15:0]             out_timestamp_sn,
  output logic signed [15:0]      out_i,
  output logic signed [15:0]      out_q,
  output logic [31:0]             out_drop_count,
  output logic                    out_last
);
  import iqfr_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  assign cfg_ready = 1'b1;

  iqfr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  iqfr_dp #(
    .MAX_SLOTS        (MAX_SLOTS),
    .FRAGS_PER_SET    (FRAGS_PER_SET),
    .SAMPLES_PER_FRAG (SAMPLES_PER_FRAG)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_valid         (cfg_valid),
    .cfg_data          (cfg_data),
    .in_command        (in_command),
    .in_conn_id        (in_conn_id),
    .in_report_idx     (in_report_idx),
    .in_timestamp_sn   (in_timestamp_sn),
    .in_es_sn          (in_es_sn),
    .in_rssi           (in_rssi),
    .in_sample_count   (in_sample_count),
    .in_link_ready     (in_link_ready),
    .in_i_data         (in_i_data),
    .in_q_data         (in_q_data),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_status        (out_status),
    .out_conn_id       (out_conn_id),
    .out_total_samples (out_total_samples),
    .out_rssi          (out_rssi),
    .out_es_sn         (out_es_sn),
    .out_timestamp_sn  (out_timestamp_sn),
    .out_i             (out_i),
    .out_q             (out_q),
    .out_drop_count    (out_drop_count),
    .out_last          (out_last)
  );

endmodule
`default_nettype wire
